// ----- design/slis_pkg.sv -----
`default_nettype none

package slis_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    // The first-match search works in groups of eight cells.
    localparam int GROUP = 8;
    localparam int GROUP_W = 3;
    localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
    localparam int NGRP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PAD_W = NUM_GROUPS * GROUP;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_APPLY
    } slis_state_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } slis_item_t;

    typedef struct packed {
        logic [6:0] position;
        logic       overflow;
        logic [6:0] count;
    } slis_result_t;

endpackage

`default_nettype wire

// ----- design/slis_cell.sv -----
`default_nettype none

module slis_cell
    import slis_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               cmp_en,
    input  wire logic               shift_en,
    input  wire logic signed [31:0] key,
    input  wire logic               occupied,
    input  wire logic signed [31:0] left_entry,
    input  wire logic               left_greater,
    output logic signed [31:0]      entry,
    output logic                    greater,
    output logic                    match
);

    logic signed [31:0] entry_reg;
    logic               greater_reg;
    logic               match_reg;

    // An empty cell counts as greater, so the new key lands in the first free cell
    // when no stored entry is larger.
    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            greater_reg <= !occupied || (key < entry_reg);
            match_reg   <= occupied && (key == entry_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en && greater_reg)
        begin
            entry_reg <= left_greater ? left_entry : key;
        end
    end

    assign entry   = entry_reg;
    assign greater = greater_reg;
    assign match   = match_reg;

endmodule

`default_nettype wire

// ----- design/slis_first.sv -----
`default_nettype none

module slis_first
    import slis_pkg::*;
(
    input  wire logic [CAPACITY-1:0] hits,
    output logic                     found,
    output logic [IDX_W-1:0]         index
);

    logic [PAD_W-1:0]         padded;
    logic [NUM_GROUPS-1:0]    grp_any;
    logic [GROUP_W-1:0]       grp_idx [NUM_GROUPS];
    logic [NGRP_W-1:0]        sel_grp;
    logic [GROUP_W-1:0]       sel_idx;

    assign padded = PAD_W'(hits);

    // Lowest set bit inside each group; groups are independent.
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_any[g] = |padded[g*GROUP +: GROUP];
            grp_idx[g] = '0;
            for (int b = GROUP - 1; b >= 0; b--)
            begin
                if (padded[g*GROUP + b])
                begin
                    grp_idx[g] = GROUP_W'(b);
                end
            end
        end
    end

    always_comb
    begin
        sel_grp = '0;
        sel_idx = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                sel_grp = NGRP_W'(g);
                sel_idx = grp_idx[g];
            end
        end
    end

    assign found = |grp_any;
    assign index = IDX_W'({sel_grp, sel_idx});

endmodule

`default_nettype wire

// ----- design/sorted_list_insert_search_unit.sv -----
// Sorted list of up to 64 signed 32-bit keys, kept as a row of cells. Raise start with an
// item while busy is low; in the next cycle busy is high for exactly one cycle while every cell
// compares its entry with the key. The next cycle applies the item (cells shift up to make
// room for an insert, the first match is encoded for a search), and the result word appears on
// result with done high for one cycle after that. A new item may be started in the cycle the
// previous one is applied, so a new item can enter before the last one is through. Each item
// passes a compare and an apply phase of the cell row. Results cannot be held off: capture
// result whenever done is high. An insert into a full list is dropped and flagged by overflow.
`default_nettype none

module sorted_list_insert_search_unit
    import slis_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire slis_item_t   item,
    output logic              busy,
    output logic              done,
    output slis_result_t      result
);

    slis_state_t        state_reg;
    slis_state_t        state_next;
    slis_item_t         op_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               done_reg;
    slis_result_t       result_reg;
    slis_result_t       result_next;

    logic               accept;
    logic               cmp_en;
    logic               apply_en;
    logic               full;
    logic               shift_en;

    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] greater;
    logic [CAPACITY-1:0] match;
    logic signed [31:0]  entry [CAPACITY];

    logic                hit_found;
    logic [IDX_W-1:0]    hit_index;

    assign accept = start && !busy;
    assign full   = (count_reg == COUNT_W'(CAPACITY));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    state_next = start ? ST_COMPARE : ST_IDLE;
            ST_COMPARE: state_next = ST_APPLY;
            ST_APPLY:   state_next = start ? ST_COMPARE : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = 1'b0;
        cmp_en   = 1'b0;
        apply_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:    ;
            ST_COMPARE:
            begin
                busy   = 1'b1;
                cmp_en = 1'b1;
            end
            ST_APPLY:   apply_en = 1'b1;
            default:    ;
        endcase
    end

    assign shift_en = apply_en && (op_reg.kind == KIND_INSERT) && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= apply_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= item;
        end
        if (apply_en)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (shift_en)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_comb
    begin
        result_next.position = '0;
        result_next.overflow = 1'b0;
        result_next.count    = 7'(count_next);
        if (op_reg.kind == KIND_SEARCH)
        begin
            if (hit_found)
            begin
                result_next.position = 7'({1'b0, hit_index} + (IDX_W + 1)'(1));
            end
        end
        else
        begin
            result_next.overflow = full;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cells
        assign occupied[i] = (COUNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            slis_cell u_cell (
                .clk          (clk),
                .cmp_en       (cmp_en),
                .shift_en     (shift_en),
                .key          (op_reg.value),
                .occupied     (occupied[i]),
                .left_entry   (op_reg.value),
                .left_greater (1'b0),
                .entry        (entry[i]),
                .greater      (greater[i]),
                .match        (match[i])
            );
        end
        else
        begin : g_body
            slis_cell u_cell (
                .clk          (clk),
                .cmp_en       (cmp_en),
                .shift_en     (shift_en),
                .key          (op_reg.value),
                .occupied     (occupied[i]),
                .left_entry   (entry[i-1]),
                .left_greater (greater[i-1]),
                .entry        (entry[i]),
                .greater      (greater[i]),
                .match        (match[i])
            );
        end
    end

    slis_first u_first (
        .hits  (match),
        .found (hit_found),
        .index (hit_index)
    );

    assign done   = done_reg;
    assign result = result_reg;

    // The compare phase never lasts more than one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
        else $error("compare phase held busy for two cycles");

    // An accepted word always enters the compare phase next.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted word did not start a compare");

    // The fill count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= COUNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // A dropped insert reports a full list and no position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (result.count == 7'(CAPACITY) && result.position == 7'd0))
        else $error("overflow reported with a list that is not full");

    // Every applied item produces a result word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) apply_en |=> done)
        else $error("applied item gave no result");

endmodule

`default_nettype wire
